FILE: sv/masked_sbox_table_compression_top_defines.svh
// Assertion macros for the masked S-box table block.
// Used by the top level only; no other dependencies.
`ifndef MASKED_SBOX_TABLE_COMPRESSION_TOP_DEFINES_SVH
`define MASKED_SBOX_TABLE_COMPRESSION_TOP_DEFINES_SVH
// Implication checked on every rising edge outside reset.
`define MSTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define MSTC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: sv/mstc_pkg.sv
// Package for the masked S-box table block: payload types, S-box table and
// helper functions. No dependencies.
package mstc_pkg;

  typedef struct packed {
    logic        op;
    logic [7:0]  table_index;
    logic [7:0]  share0;
    logic [7:0]  share1;
    logic [7:0]  share2;
    logic        rand_w;
    logic [13:0] rand_r;
    logic [63:0] rand_gamma;
    logic [15:0] rand_y2;
    logic        rand_vs;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_share0;
    logic [7:0] out_share1;
    logic [7:0] out_share2;
    logic       is_lookup;
  } out_item_t;

  localparam logic OP_BUILD  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;     // capture the accepted item
    logic build;    // write one table entry at the current counter
    logic lk_rd;    // issue the table read for a lookup
    logic lk_fin;   // form the lookup result
    logic ack;      // form a build acknowledge / empty result
  } ctl_cmd_t;

  typedef struct packed {
    logic last;     // entry counter at its final value
    logic op;       // operation of the captured item
    logic in_range; // table index of the captured item is valid
  } ctl_sts_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] s [256];
    s = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return s[a];
  endfunction

endpackage

FILE: sv/mstc_ctrl.sv
// Controller for the masked S-box table block: sequences table builds and
// lookups. Uses mstc_pkg.
module mstc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  mstc_pkg::ctl_sts_t sts_i,
  output mstc_pkg::ctl_cmd_t cmd_o
);
  import mstc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_BUILD = 3'd2;
  localparam logic [2:0] S_LKRD  = 3'd3;
  localparam logic [2:0] S_LKFIN = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       acc_in;

  // A new item may enter in the cycle that the previous result leaves.
  assign in_stall_o  = !(state_q == S_IDLE || (state_q == S_OUT && !out_stall_i));
  assign out_valid_o = (state_q == S_OUT);
  assign acc_in      = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.load = acc_in;
    unique case (state_q)
      S_IDLE: begin
        if (acc_in) state_d = S_DISP;
      end
      S_DISP: begin
        if (!sts_i.in_range) begin
          cmd_o.ack = 1'b1;
          state_d   = S_OUT;
        end else if (sts_i.op == OP_BUILD) begin
          state_d = S_BUILD;
        end else begin
          cmd_o.lk_rd = 1'b1;
          state_d     = S_LKRD;
        end
      end
      S_BUILD: begin
        cmd_o.build = 1'b1;
        if (sts_i.last) begin
          cmd_o.ack = 1'b1;
          state_d   = S_OUT;
        end
      end
      S_LKRD: state_d = S_LKFIN;
      S_LKFIN: begin
        cmd_o.lk_fin = 1'b1;
        state_d      = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) state_d = acc_in ? S_DISP : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end
endmodule

FILE: sv/mstc_dpath.sv
// Datapath for the masked S-box table block: per-table memories, entry
// builder and lookup unpacker. Uses mstc_pkg.
module mstc_dpath #(
  parameter int NumTables = 160
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mstc_pkg::in_item_t in_i,
  input  mstc_pkg::ctl_cmd_t cmd_i,
  output mstc_pkg::ctl_sts_t sts_o,
  output mstc_pkg::out_item_t out_o
);
  import mstc_pkg::*;

  localparam int TW = (NumTables > 1) ? $clog2(NumTables) : 1;

  in_item_t   it_q;
  logic [6:0] cnt_q;
  out_item_t  res_q;

  // Per-table stores; one write port, one read port each.
  logic [7:0]  tab_mem [NumTables*128];
  logic [94:0] par_mem [NumTables];   // {x1, x2, r1, r0, w, gamma}
  logic [7:0]  tab_rd_q;
  logic [94:0] par_rd_q;

  logic [TW-1:0] tix;
  assign tix = it_q.table_index[TW-1:0];

  assign sts_o.op       = it_q.op;
  assign sts_o.last     = (cnt_q == 7'h7f);
  assign sts_o.in_range = ({24'd0, it_q.table_index} < NumTables);

  // Build values for entry a = cnt_q.
  logic [6:0] vf, shr, b, hi0, hi1;
  logic [6:0] r0, r1;
  logic [7:0] sm_b, ent;

  function automatic logic [7:0] subset(input logic [63:0] g, input logic [6:0] bb);
    logic [7:0] acc;
    acc = g[63:56];
    for (int k = 0; k < 7; k++) if (bb[k]) acc ^= g[8*k +: 8];
    return acc;
  endfunction

  always_comb begin
    vf  = it_q.share2[7:1];
    r0  = it_q.rand_r[6:0];
    r1  = it_q.rand_r[13:7];
    shr = it_q.share0[7:1] ^ vf ^ it_q.share1[7:1];
    b   = cnt_q ^ shr;
    sm_b = subset(it_q.rand_gamma, b);
    hi0 = cnt_q ^ (it_q.rand_w ? r1 : r0) ^ vf;
    hi1 = cnt_q ^ (it_q.rand_w ? r0 : r1) ^ vf;
    ent = sm_b ^ sbox({hi0, it_q.share0[0]}) ^ sbox({hi1, ~it_q.share0[0]});
  end

  // Lookup: table address and result shares from stored parameters.
  logic [7:0]  px1, px2, x3;
  logic [6:0]  pr0, pr1, rsel, hi_l, h2;
  logic        pw, itr, vs, bsel;
  logic [63:0] pg;
  logic [7:0]  y2sel, sm_o, t2;

  always_comb begin
    {px1, px2, pr1, pr0, pw, pg} = par_rd_q;
    x3   = it_q.share0 ^ it_q.share1 ^ it_q.share2 ^ px1 ^ px2;
    vs   = it_q.rand_vs;
    itr  = px1[0] ^ x3[0] ^ pw;
    // Only the entry whose unpacked position equals vs reaches the output;
    // vs cancels out of that entry's index, leaving the low bits of x1 and x2.
    bsel = px1[0] ^ px2[0];
    rsel = (itr ^ bsel) ? pr1 : pr0;
    hi_l = x3[7:1] ^ rsel;
    h2   = hi_l ^ px1[7:1] ^ ((itr ^ ~bsel) ? pr1 : pr0) ^ px2[7:1];
    y2sel = vs ? it_q.rand_y2[15:8] : it_q.rand_y2[7:0];
    t2   = tab_rd_q ^ y2sel ^ sbox({h2, x3[0] ^ ~bsel});
    sm_o = subset(pg, x3[7:1] ^ ((px2[0] ^ x3[0] ^ pw) ? pr1 : pr0));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) it_q <= in_i;
    if (cmd_i.build) begin
      tab_mem[{tix, b}] <= ent;
      if (cnt_q == '0)
        par_mem[tix] <= {it_q.share0, it_q.share1, r1, r0, it_q.rand_w, it_q.rand_gamma};
    end
    par_rd_q <= par_mem[tix];
    tab_rd_q <= tab_mem[{tix, hi_l}];
    if (cmd_i.ack)    res_q <= '0;
    if (cmd_i.lk_fin) res_q <= '{sm_o, y2sel, t2, 1'b1};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)          cnt_q <= '0;
    else if (cmd_i.build) cnt_q <= cnt_q + 7'd1;
  end

  assign out_o = res_q;
endmodule

FILE: sv/masked_sbox_table_compression_top.sv
// Channel | dir | handshake          | payload
// in      | in  | in_valid_i/stall_o | in_i  (mstc_pkg::in_item_t)
// out     | out | out_valid_o/stall_i| out_o (mstc_pkg::out_item_t)
// A build runs a dispatch step, then writes one table entry per cycle through
// the single table write port. A lookup runs dispatch, parameter read, table
// read and result. Out-of-range items go from dispatch straight to the result.
// Reset clears control only; tables hold nothing until built.
// A stalled result holds in its register; the next item is accepted once it leaves.
module masked_sbox_table_compression_top #(
  parameter int NUM_TABLES = 160
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mstc_pkg::in_item_t  in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mstc_pkg::out_item_t out_o
);
  import mstc_pkg::*;
  `include "masked_sbox_table_compression_top_defines.svh"

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  mstc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  mstc_dpath #(.NumTables(NUM_TABLES)) u_dpath (
    .clk_i, .rst_ni, .in_i, .cmd_i(cmd), .sts_o(sts), .out_o
  );

  `MSTC_ASSERT_IMP(a_no_accept_busy, cmd.build, in_stall_o, "item accepted mid-build")
  `MSTC_ASSERT_NXT(a_fin_valid, cmd.lk_fin, out_valid_o && out_o.is_lookup,
                   "lookup result missing")
  `MSTC_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0({cmd.build, cmd.lk_rd, cmd.lk_fin}),
                   "conflicting datapath commands")
endmodule

FILE: verif/testbench.sv
// Testbench for the masked S-box table block: builds tables, performs
// masked lookups and checks every result against a local predictor.
// Depends on mstc_pkg and masked_sbox_table_compression_top.
`timescale 1ns / 1ps

module testbench;
  import mstc_pkg::*;

  localparam int NTAB = 160;
  localparam int HALF = 128;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_o;

  masked_sbox_table_compression_top u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_i,
    .out_valid_o, .out_stall_i, .out_o
  );

  always #2 clk_i = ~clk_i;

  // Predictor state, one copy per table.
  logic [7:0]  pred_packed [NTAB][HALF];
  logic [6:0]  pred_r [NTAB][2];
  logic        pred_w [NTAB];
  logic [63:0] pred_gamma [NTAB];
  logic [7:0]  pred_x1 [NTAB];
  logic [7:0]  pred_x2 [NTAB];
  bit          built [NTAB];

  out_item_t expected_shares [$];
  int  fail_count = 0;
  bit  idle_enable = 1'b1;

  function automatic logic [7:0] sbox_at(logic [6:0] hi, logic lo);
    logic [7:0] s [256];
    s = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return s[{hi, lo}];
  endfunction

  // Gamma byte 7 XORed with gamma byte k for every set bit k of sel.
  function automatic logic [7:0] gamma_mask(int t, logic [6:0] sel);
    logic [7:0] acc;
    acc = pred_gamma[t][63:56];
    for (int k = 0; k < 7; k++)
      if (sel[k]) acc ^= pred_gamma[t][8*k +: 8];
    return acc;
  endfunction

  function automatic out_item_t predict_shares(in_item_t it);
    out_item_t   res;
    int          t;
    logic [6:0]  vf, shr7, sel, hi, h2;
    logic [7:0]  acc, x3, y2 [2], t2 [2];
    logic        shr, itr, iz, b;
    res = '0;
    t = it.table_index;
    if (t >= NTAB) return res;
    if (it.op == OP_BUILD) begin
      pred_r[t][0] = it.rand_r[6:0];
      pred_r[t][1] = it.rand_r[13:7];
      pred_w[t] = it.rand_w;
      pred_gamma[t] = it.rand_gamma;
      pred_x1[t] = it.share0;
      pred_x2[t] = it.share1;
      built[t] = 1'b1;
      vf = it.share2[7:1];
      shr7 = it.share0[7:1] ^ vf ^ it.share1[7:1];
      for (int a = 0; a < HALF; a++) begin
        sel = 7'(a) ^ shr7;
        acc = gamma_mask(t, sel);
        for (int k = 0; k < 2; k++) begin
          hi = 7'(a) ^ pred_r[t][k[0] ^ pred_w[t]] ^ vf;
          acc ^= sbox_at(hi, it.share0[0] ^ k[0]);
        end
        pred_packed[t][sel] = acc;
      end
      return res;
    end
    x3 = it.share0 ^ it.share1 ^ it.share2 ^ pred_x1[t] ^ pred_x2[t];
    shr = pred_x1[t][0] ^ it.rand_vs ^ pred_x2[t][0];
    itr = pred_x1[t][0] ^ x3[0] ^ pred_w[t];
    y2[0] = it.rand_y2[7:0];
    y2[1] = it.rand_y2[15:8];
    for (int a = 0; a < 2; a++) begin
      b = a[0] ^ shr;
      hi = x3[7:1] ^ pred_r[t][itr ^ a[0]];
      acc = pred_packed[t][hi] ^ y2[b];
      for (int k = 0; k < 2; k++)
        if (k != a) begin
          h2 = hi ^ pred_x1[t][7:1] ^ pred_r[t][itr ^ k[0]] ^ pred_x2[t][7:1];
          acc ^= sbox_at(h2, x3[0] ^ k[0]);
        end
      t2[b] = acc;
    end
    iz = pred_x2[t][0] ^ x3[0] ^ pred_w[t];
    res.out_share0 = gamma_mask(t, x3[7:1] ^ pred_r[t][iz]);
    res.out_share1 = y2[it.rand_vs];
    res.out_share2 = t2[it.rand_vs];
    res.is_lookup = 1'b1;
    return res;
  endfunction

  // Sends one item, with an optional random gap first, and records its result.
  // Valid stays high after the transfer so that items can follow directly.
  task automatic send_item(in_item_t it);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    expected_shares.push_back(predict_shares(it));
  endtask

  function automatic in_item_t random_item(logic op, int t);
    in_item_t it;
    it.op = op;
    it.table_index = 8'(t);
    it.share0 = 8'($urandom);
    it.share1 = 8'($urandom);
    it.share2 = 8'($urandom);
    it.rand_w = 1'($urandom);
    it.rand_r = 14'($urandom);
    it.rand_gamma = {$urandom, $urandom};
    it.rand_y2 = 16'($urandom);
    it.rand_vs = 1'($urandom);
    return it;
  endfunction

  function automatic int random_built();
    int t;
    do t = $urandom_range(0, NTAB - 1); while (!built[t]);
    return t;
  endfunction

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_shares.size() != 0) @(posedge clk_i);
    repeat (140) @(posedge clk_i);
  endtask

  // Extremes of the fields, both operations and out-of-range indices.
  task automatic test_directed();
    in_item_t it;
    it = '0;
    send_item(it);
    it = '1;
    it.op = OP_BUILD;
    it.table_index = 8'(NTAB - 1);
    send_item(it);
    it = '0;
    it.op = OP_LOOKUP;
    send_item(it);
    it = '1;
    it.table_index = 8'(NTAB - 1);
    send_item(it);
    it.table_index = 8'(NTAB);
    send_item(it);
    it.op = OP_BUILD;
    it.table_index = 8'hff;
    send_item(it);
    it.op = OP_LOOKUP;
    send_item(it);
    for (int i = 0; i < 8; i++) send_item(random_item(OP_LOOKUP, i[0] ? 0 : NTAB - 1));
  endtask

  // The sender waits for every result before going on.
  task automatic test_drain_pause();
    send_item(random_item(OP_BUILD, 5));
    wait_drained();
    send_item(random_item(OP_LOOKUP, 5));
    wait_drained();
  endtask

  // Mostly lookups through built tables, with fresh builds and out-of-range items now and then.
  task automatic test_random(int count);
    in_item_t it;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 19))
        0, 1:    it = random_item(OP_BUILD, $urandom_range(0, NTAB - 1));
        2:       it = random_item(1'($urandom), $urandom_range(NTAB, 255));
        default: it = random_item(OP_LOOKUP, random_built());
      endcase
      send_item(it);
    end
  endtask

  task automatic test_no_idling(int count);
    idle_enable = 1'b0;
    test_random(count);
  endtask

  always @(posedge clk_i) begin
    if (idle_enable && $urandom_range(0, 9) == 0) begin
      out_stall_i <= 1'b1;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    out_item_t exp_item;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_shares.size() == 0) begin
        $error("result with nothing expected: %h", out_o);
        fail_count++;
      end else begin
        exp_item = expected_shares.pop_front();
        if (out_o.out_share0 !== exp_item.out_share0) begin
          $error("out_share0 expected %h actual %h", exp_item.out_share0, out_o.out_share0);
          fail_count++;
        end
        if (out_o.out_share1 !== exp_item.out_share1) begin
          $error("out_share1 expected %h actual %h", exp_item.out_share1, out_o.out_share1);
          fail_count++;
        end
        if (out_o.out_share2 !== exp_item.out_share2) begin
          $error("out_share2 expected %h actual %h", exp_item.out_share2, out_o.out_share2);
          fail_count++;
        end
        if (out_o.is_lookup !== exp_item.is_lookup) begin
          $error("is_lookup expected %b actual %b", exp_item.is_lookup, out_o.is_lookup);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_drain_pause();
    test_random(450);
    test_no_idling(130);
    wait_drained();
    if (fail_count == 0 && expected_shares.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/mstc_pkg.sv
sv/mstc_ctrl.sv
sv/mstc_dpath.sv
sv/masked_sbox_table_compression_top.sv
verif/testbench.sv
